FILE: rtl/rfd_pkg.sv
// Shared constants, codes and byte tables for the radar frame deframer.
// No dependencies.
package rfd_pkg;

    // Parser modes
    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;
    localparam logic [1:0] MODE_PAYLOAD = 2'd2;
    localparam logic [1:0] MODE_FOOTER  = 2'd3;

    // Result event codes
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_UPDATED    = 3'd1;
    localparam logic [2:0] EV_IGNORED    = 3'd2;
    localparam logic [2:0] EV_LEN_REJECT = 3'd3;
    localparam logic [2:0] EV_FOOTER_BAD = 3'd4;

    localparam int DEF_MAX_LEN = 64;
    localparam int KEEP_BYTES  = 11;

    localparam logic [7:0] FRAME_TYPE = 8'h02;
    localparam logic [7:0] FRAME_HEAD = 8'hAA;

    typedef logic [7:0] byte_t;

    function automatic byte_t hdr_byte(input logic [1:0] idx);
        byte_t res;
        case (idx)
            2'd0:    res = 8'hF4;
            2'd1:    res = 8'hF3;
            2'd2:    res = 8'hF2;
            default: res = 8'hF1;
        endcase
        return res;
    endfunction

    function automatic byte_t ftr_byte(input logic [1:0] idx);
        byte_t res;
        case (idx)
            2'd0:    res = 8'hF8;
            2'd1:    res = 8'hF7;
            2'd2:    res = 8'hF6;
            default: res = 8'hF5;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/radar_frame_deframer_top.sv
// Radar frame deframer: byte-wise header/length/payload/footer parser and
// target record. Depends on rfd_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  s_       | in        | s_valid / s_ready  | s_rx_byte
//  m_       | out       | m_valid / m_ready  | m_event_res, m_target_code, ...
//
// One request in, one request out. Each byte is parsed in the cycle it is
// accepted; its result sits in the output register the next cycle, and one
// byte is taken every cycle while the output register is not stalled.
// The single output register sets the rate: s_ready is high whenever that
// register is empty or is being drained in the same cycle.
// aresetn (synchronous, active low) returns the parser to header search
// and clears the record; the captured payload bytes are not cleared.
// A stall on m_ready holds the result and backpressures s_ready at once.
module radar_frame_deframer_top #(
    parameter int MAX_LEN = rfd_pkg::DEF_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [7:0]  m_target_code,
    output logic [15:0] m_moving_distance,
    output logic [7:0]  m_move_energy,
    output logic [15:0] m_stationary_distance,
    output logic [7:0]  m_still_energy,
    output logic [15:0] m_detection_distance,
    output logic        m_record_valid
);
    import rfd_pkg::*;

    localparam logic [15:0] MaxLenW = 16'(MAX_LEN);
    localparam logic [6:0]  KeepW   = 7'(KEEP_BYTES);

    // Parser state
    logic [1:0] parse_mode_reg, parse_mode_next;
    logic [2:0] header_count_reg, header_count_next;
    logic [7:0] length_low_reg, length_low_next;
    logic       length_count_reg, length_count_next;
    logic [6:0] expected_length_reg, expected_length_next;
    logic [6:0] payload_position_reg, payload_position_next;
    logic [1:0] footer_count_reg, footer_count_next;

    // Captured payload: only the first KEEP_BYTES bytes of a frame
    byte_t      captured_reg [KEEP_BYTES];
    logic       cap_we;

    // Target record
    logic [7:0]  target_code_reg, target_code_next;
    logic [15:0] moving_distance_reg, moving_distance_next;
    logic [7:0]  move_energy_reg, move_energy_next;
    logic [15:0] stationary_distance_reg, stationary_distance_next;
    logic [7:0]  still_energy_reg, still_energy_next;
    logic [15:0] detection_distance_reg, detection_distance_next;
    logic        record_flag_reg, record_flag_next;

    // Output register
    logic        m_valid_reg;
    logic [2:0]  event_reg, event_next;

    logic        accept;
    logic [15:0] length_word;
    logic [6:0]  pos_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign length_word = {s_rx_byte, length_low_reg};
    assign pos_inc     = payload_position_reg + 7'd1;
    assign cap_we      = accept && (parse_mode_reg == MODE_PAYLOAD)
                         && (payload_position_reg < KeepW);

    always_comb begin
        parse_mode_next          = parse_mode_reg;
        header_count_next        = header_count_reg;
        length_low_next          = length_low_reg;
        length_count_next        = length_count_reg;
        expected_length_next     = expected_length_reg;
        payload_position_next    = payload_position_reg;
        footer_count_next        = footer_count_reg;
        target_code_next         = target_code_reg;
        moving_distance_next     = moving_distance_reg;
        move_energy_next         = move_energy_reg;
        stationary_distance_next = stationary_distance_reg;
        still_energy_next        = still_energy_reg;
        detection_distance_next  = detection_distance_reg;
        record_flag_next         = record_flag_reg;
        event_next               = EV_NONE;

        unique case (parse_mode_reg)
            MODE_HEADER: begin
                if (s_rx_byte == hdr_byte(header_count_reg[1:0])) begin
                    // Advance through the header; on the last byte go read length
                    if (header_count_reg == 3'd3) begin
                        parse_mode_next   = MODE_LENGTH;
                        length_count_next = 1'b0;
                        header_count_next = 3'd0;
                    end else begin
                        header_count_next = header_count_reg + 3'd1;
                    end
                end else begin
                    // Restart the search, counting this byte if it opens a header
                    header_count_next = (s_rx_byte == hdr_byte(2'd0)) ? 3'd1 : 3'd0;
                end
            end
            MODE_LENGTH: begin
                if (!length_count_reg) begin
                    length_low_next   = s_rx_byte;
                    length_count_next = 1'b1;
                end else begin
                    length_count_next = 1'b0;
                    if (length_word > MaxLenW) begin
                        event_next        = EV_LEN_REJECT;
                        parse_mode_next   = MODE_HEADER;
                        header_count_next = 3'd0;
                    end else begin
                        expected_length_next  = length_word[6:0];
                        payload_position_next = 7'd0;
                        parse_mode_next       = MODE_PAYLOAD;
                    end
                end
            end
            MODE_PAYLOAD: begin
                // A zero length still takes one byte here
                payload_position_next = pos_inc;
                if (pos_inc >= expected_length_reg) begin
                    parse_mode_next   = MODE_FOOTER;
                    footer_count_next = 2'd0;
                end
            end
            MODE_FOOTER: begin
                if (s_rx_byte == ftr_byte(footer_count_reg)) begin
                    if (footer_count_reg == 2'd3) begin
                        footer_count_next = 2'd0;
                        parse_mode_next   = MODE_HEADER;
                        header_count_next = 3'd0;
                        if (expected_length_reg < KeepW
                            || captured_reg[0] != FRAME_TYPE
                            || captured_reg[1] != FRAME_HEAD) begin
                            event_next = EV_IGNORED;
                        end else begin
                            event_next               = EV_UPDATED;
                            target_code_next         = captured_reg[2];
                            moving_distance_next     = {captured_reg[4], captured_reg[3]};
                            move_energy_next         = captured_reg[5];
                            stationary_distance_next = {captured_reg[7], captured_reg[6]};
                            still_energy_next        = captured_reg[8];
                            detection_distance_next  = {captured_reg[10], captured_reg[9]};
                            record_flag_next         = 1'b1;
                        end
                    end else begin
                        footer_count_next = footer_count_reg + 2'd1;
                    end
                end else begin
                    // Resync; footer_count is left as is
                    event_next        = EV_FOOTER_BAD;
                    parse_mode_next   = MODE_HEADER;
                    header_count_next = (s_rx_byte == hdr_byte(2'd0)) ? 3'd1 : 3'd0;
                end
            end
            default: begin
                parse_mode_next = MODE_HEADER;
            end
        endcase
    end

    // Control, record and output registers: update on an accepted request; valid drops once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_mode_reg          <= MODE_HEADER;
            header_count_reg        <= 3'd0;
            length_low_reg          <= 8'd0;
            length_count_reg        <= 1'b0;
            expected_length_reg     <= 7'd0;
            payload_position_reg    <= 7'd0;
            footer_count_reg        <= 2'd0;
            target_code_reg         <= 8'd0;
            moving_distance_reg     <= 16'd0;
            move_energy_reg         <= 8'd0;
            stationary_distance_reg <= 16'd0;
            still_energy_reg        <= 8'd0;
            detection_distance_reg  <= 16'd0;
            record_flag_reg         <= 1'b0;
            m_valid_reg             <= 1'b0;
            event_reg               <= EV_NONE;
        end else begin
            if (accept) begin
                parse_mode_reg          <= parse_mode_next;
                header_count_reg        <= header_count_next;
                length_low_reg          <= length_low_next;
                length_count_reg        <= length_count_next;
                expected_length_reg     <= expected_length_next;
                payload_position_reg    <= payload_position_next;
                footer_count_reg        <= footer_count_next;
                target_code_reg         <= target_code_next;
                moving_distance_reg     <= moving_distance_next;
                move_energy_reg         <= move_energy_next;
                stationary_distance_reg <= stationary_distance_next;
                still_energy_reg        <= still_energy_next;
                detection_distance_reg  <= detection_distance_next;
                record_flag_reg         <= record_flag_next;
                event_reg               <= event_next;
                m_valid_reg             <= 1'b1;
            end else if (m_ready) begin
                // Drop the result once it has been taken
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload capture: no reset, only read after being written in the same frame
    always_ff @(posedge aclk) begin
        if (cap_we) begin
            captured_reg[payload_position_reg[3:0]] <= s_rx_byte;
        end
    end

    // Record registers change only on an accept, which frees the output
    // register in the same edge, so they drive the result ports directly.
    assign m_valid               = m_valid_reg;
    assign m_event_res           = event_reg;
    assign m_target_code         = target_code_reg;
    assign m_moving_distance     = moving_distance_reg;
    assign m_move_energy         = move_energy_reg;
    assign m_stationary_distance = stationary_distance_reg;
    assign m_still_energy        = still_energy_reg;
    assign m_detection_distance  = detection_distance_reg;
    assign m_record_valid        = record_flag_reg;

`ifndef SYNTH
    // The valid flag is sticky until reset
    a_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(record_flag_reg))
        else $error("record flag dropped");

    // An update event always comes with a valid record
    a_update_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && event_reg == EV_UPDATED) |-> record_flag_reg)
        else $error("update event without valid record");

    // A stalled result blocks new input
    a_stall_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    // The header counter never holds a full header
    a_hdr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        header_count_reg <= 3'd3)
        else $error("header count out of range");

    // Payload length in force never exceeds the limit
    a_len_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (parse_mode_reg == MODE_PAYLOAD) |-> (16'(expected_length_reg) <= MaxLenW))
        else $error("payload length above limit");
`endif

endmodule

FILE: tb/tb_radar_frame_deframer_top.sv
// Self-checking testbench for radar_frame_deframer_top: byte stream in, one event/record out.
// Uses rfd_pkg for event codes, mode codes and frame constants.
// A queue-fed driver, a clocked monitor and a bit-exact frame parser predictor.
`timescale 1ns / 100ps

module tb_radar_frame_deframer_top;
    import rfd_pkg::*;

    localparam int MAX_LEN     = DEF_MAX_LEN;
    localparam int ITEM_TARGET = 1150;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_ITEM = 500;

    // Header and footer bytes, first byte in the low lane
    localparam logic [31:0] HDR_WORD = 32'hF1F2F3F4;
    localparam logic [31:0] FTR_WORD = 32'hF5F6F7F8;

    // Payload fill patterns for generated frames
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    // Footer cut position meaning "no cut"
    localparam int CUT_NONE = 4;

    // Flow-control phases, stepped by the number of accepted requests
    localparam logic [1:0] PH_FLOW       = 2'd0;
    localparam logic [1:0] PH_SEND_IDLE  = 2'd1;
    localparam logic [1:0] PH_RECV_STALL = 2'd2;
    localparam logic [1:0] PH_BOTH       = 2'd3;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  target_code;
        logic [15:0] moving_distance;
        logic [7:0]  move_energy;
        logic [15:0] stationary_distance;
        logic [7:0]  still_energy;
        logic [15:0] detection_distance;
        logic        record_valid;
    } frame_result_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_res;
    logic [7:0]  m_target_code;
    logic [15:0] m_moving_distance;
    logic [7:0]  m_move_energy;
    logic [15:0] m_stationary_distance;
    logic [7:0]  m_still_energy;
    logic [15:0] m_detection_distance;
    logic        m_record_valid;

    radar_frame_deframer_top #(
        .MAX_LEN(MAX_LEN)
    ) u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_event_res          (m_event_res),
        .m_target_code        (m_target_code),
        .m_moving_distance    (m_moving_distance),
        .m_move_energy        (m_move_energy),
        .m_stationary_distance(m_stationary_distance),
        .m_still_energy       (m_still_energy),
        .m_detection_distance (m_detection_distance),
        .m_record_valid       (m_record_valid)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    byte_t         pending_bytes[$];
    frame_result_t expected_results[$];
    int            fail_count = 0;
    logic [31:0]   sent_count = '0;
    logic [1:0]    idle_phase;
    logic          hold_active = 1'b0;
    logic          hold_done   = 1'b0;
    int            hold_left   = 0;

    // Step the idling phase every 128 accepted requests
    assign idle_phase = sent_count[8:7];

    // ------------------------------------------------------------------
    // Parser predictor: its own copy of the deframer state and record.
    // ------------------------------------------------------------------
    logic [1:0]    prs_mode      = MODE_HEADER;
    logic [2:0]    prs_hdr_cnt   = '0;
    byte_t         prs_len_lo    = '0;
    logic          prs_len_phase = 1'b0;
    logic [6:0]    prs_exp_len   = '0;
    logic [6:0]    prs_pos       = '0;
    logic [1:0]    prs_ftr_cnt   = '0;
    byte_t         prs_payload[KEEP_BYTES];
    frame_result_t target_record = '0;

    task automatic parse_byte(input byte_t b, output frame_result_t res);
        logic [15:0] len;
        logic [2:0]  ev;
        ev = EV_NONE;
        case (prs_mode)
            MODE_HEADER: begin
                if (b == HDR_WORD[prs_hdr_cnt[1:0]*8 +: 8]) begin
                    if (prs_hdr_cnt == 3'd3) begin
                        prs_mode      = MODE_LENGTH;
                        prs_len_phase = 1'b0;
                        prs_hdr_cnt   = '0;
                    end else begin
                        prs_hdr_cnt = prs_hdr_cnt + 3'd1;
                    end
                end else begin
                    // Restart the search, counting an F4 as a fresh start
                    prs_hdr_cnt = (b == HDR_WORD[7:0]) ? 3'd1 : 3'd0;
                end
            end
            MODE_LENGTH: begin
                if (!prs_len_phase) begin
                    prs_len_lo    = b;
                    prs_len_phase = 1'b1;
                end else begin
                    len           = {b, prs_len_lo};
                    prs_len_phase = 1'b0;
                    if (len > MAX_LEN) begin
                        ev          = EV_LEN_REJECT;
                        prs_mode    = MODE_HEADER;
                        prs_hdr_cnt = '0;
                    end else begin
                        prs_exp_len = len[6:0];
                        prs_pos     = '0;
                        prs_mode    = MODE_PAYLOAD;
                    end
                end
            end
            MODE_PAYLOAD: begin
                // Keep only the leading bytes; count the rest
                if (prs_pos < KEEP_BYTES)
                    prs_payload[prs_pos] = b;
                prs_pos = prs_pos + 7'd1;
                // A zero length still swallows one byte here
                if (prs_pos >= prs_exp_len) begin
                    prs_mode    = MODE_FOOTER;
                    prs_ftr_cnt = '0;
                end
            end
            default: begin
                if (b == FTR_WORD[prs_ftr_cnt*8 +: 8]) begin
                    if (prs_ftr_cnt == 2'd3) begin
                        if (prs_exp_len < KEEP_BYTES || prs_payload[0] != FRAME_TYPE ||
                            prs_payload[1] != FRAME_HEAD) begin
                            ev = EV_IGNORED;
                        end else begin
                            target_record.target_code         = prs_payload[2];
                            target_record.moving_distance     = {prs_payload[4], prs_payload[3]};
                            target_record.move_energy         = prs_payload[5];
                            target_record.stationary_distance = {prs_payload[7], prs_payload[6]};
                            target_record.still_energy        = prs_payload[8];
                            target_record.detection_distance  = {prs_payload[10], prs_payload[9]};
                            target_record.record_valid        = 1'b1;
                            ev = EV_UPDATED;
                        end
                        prs_ftr_cnt = '0;
                        prs_mode    = MODE_HEADER;
                        prs_hdr_cnt = '0;
                    end else begin
                        prs_ftr_cnt = prs_ftr_cnt + 2'd1;
                    end
                end else begin
                    ev          = EV_FOOTER_BAD;
                    prs_mode    = MODE_HEADER;
                    prs_hdr_cnt = (b == HDR_WORD[7:0]) ? 3'd1 : 3'd0;
                end
            end
        endcase
        res           = target_record;
        res.event_res = ev;
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    // Append one frame; hdr_from skips leading header bytes, cut_at breaks
    // the footer at that byte with cut_byte (never a matching footer byte).
    task automatic push_frame(input logic [15:0] len, input byte_t id_type,
                              input byte_t id_head, input int fill, input int cut_at,
                              input byte_t cut_byte, input int hdr_from);
        int    body_len;
        byte_t b;
        for (int i = hdr_from; i < 4; i++)
            pending_bytes.push_back(HDR_WORD[i*8 +: 8]);
        pending_bytes.push_back(len[7:0]);
        pending_bytes.push_back(len[15:8]);
        if (len > MAX_LEN)
            return;
        body_len = (len == 0) ? 1 : int'(len);
        for (int i = 0; i < body_len; i++) begin
            if (i == 0)
                b = id_type;
            else if (i == 1)
                b = id_head;
            else if (fill == FILL_ZERO)
                b = 8'h00;
            else if (fill == FILL_ONES)
                b = 8'hFF;
            else
                b = byte_t'($urandom_range(255));
            pending_bytes.push_back(b);
        end
        for (int i = 0; i < 4; i++) begin
            if (i == cut_at) begin
                b = cut_byte;
                if (b == FTR_WORD[i*8 +: 8])
                    b = b ^ 8'h01;
                pending_bytes.push_back(b);
                break;
            end
            pending_bytes.push_back(FTR_WORD[i*8 +: 8]);
        end
    endtask

    task automatic push_noise(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            // Bias toward marker bytes to provoke partial matches
            if (pick < 15)
                pending_bytes.push_back(HDR_WORD[$urandom_range(3)*8 +: 8]);
            else if (pick < 25)
                pending_bytes.push_back(FTR_WORD[$urandom_range(3)*8 +: 8]);
            else
                pending_bytes.push_back(byte_t'($urandom_range(255)));
        end
    endtask

    task automatic build_stimulus();
        int          pick;
        logic [15:0] len;
        byte_t       id_type;
        byte_t       id_head;
        int          cut_at;
        byte_t       cut_byte;

        // Directed: extremes, every event, each corner of the parser
        push_noise(0);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        push_frame(16'd11, FRAME_TYPE, FRAME_HEAD, FILL_ONES, CUT_NONE, 8'h00, 0);
        push_frame(16'd11, FRAME_TYPE, FRAME_HEAD, FILL_ZERO, CUT_NONE, 8'h00, 0);
        push_frame(16'(MAX_LEN), FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        push_frame(16'(MAX_LEN + 1), FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        push_frame(16'hFFFF, FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        push_frame(16'd0, FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        push_frame(16'd10, FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        push_frame(16'd11, 8'h03, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        push_frame(16'd11, FRAME_TYPE, 8'hAB, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        // Header restart on a repeated F4, and after a partial match
        pending_bytes.push_back(HDR_WORD[7:0]);
        push_frame(16'd12, FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        pending_bytes.push_back(HDR_WORD[7:0]);
        pending_bytes.push_back(HDR_WORD[15:8]);
        push_frame(16'd11, FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 0);
        // Footer broken by F4: the next header already counts that byte
        push_frame(16'd11, FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, 2, HDR_WORD[7:0], 0);
        push_frame(16'd13, FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, CUT_NONE, 8'h00, 1);
        push_frame(16'd11, FRAME_TYPE, FRAME_HEAD, FILL_RANDOM, 0, 8'h00, 0);

        // Random: mostly well-formed frames, the rest broken frames and noise
        while (pending_bytes.size() < ITEM_TARGET) begin
            pick     = $urandom_range(99);
            id_type  = ($urandom_range(99) < 85) ? FRAME_TYPE : byte_t'($urandom_range(255));
            id_head  = ($urandom_range(99) < 85) ? FRAME_HEAD : byte_t'($urandom_range(255));
            cut_at   = CUT_NONE;
            cut_byte = ($urandom_range(1) != 0) ? HDR_WORD[7:0] : byte_t'($urandom_range(255));
            if (pick < 65) begin
                len = ($urandom_range(9) == 0) ? 16'($urandom_range(MAX_LEN, 21))
                                               : 16'($urandom_range(20, 11));
            end else if (pick < 75) begin
                len = 16'($urandom_range(10));
            end else if (pick < 82) begin
                len = ($urandom_range(1) != 0) ? 16'($urandom_range(255, MAX_LEN + 1))
                                               : 16'($urandom_range(65535, 256));
            end else if (pick < 90) begin
                len    = 16'($urandom_range(20, 11));
                cut_at = $urandom_range(3);
            end else begin
                len = '0;
            end
            if (pick < 90)
                push_frame(len, id_type, id_head, FILL_RANDOM, cut_at, cut_byte, 0);
            else
                push_noise($urandom_range(8, 1));
        end
    endtask

    function automatic int send_idle_pct(input logic [1:0] ph);
        return (ph == PH_SEND_IDLE) ? 66 : (ph == PH_BOTH) ? 13 : 0;
    endfunction

    function automatic int recv_stall_pct(input logic [1:0] ph);
        return (ph == PH_RECV_STALL) ? 66 : (ph == PH_BOTH) ? 13 : 0;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: predict on every accepted request, then offer the next byte.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        frame_result_t res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte, res);
                expected_results.push_back(res);
                sent_count <= sent_count + 32'd1;
            end
            if (s_valid && !s_ready) begin
                // Hold the request and its byte until accepted
            end else if (pending_bytes.size() != 0 &&
                         $urandom_range(99) >= send_idle_pct(idle_phase)) begin
                s_valid   <= 1'b1;
                s_rx_byte <= pending_bytes.pop_front();
            end else begin
                // Drop valid: nothing left, or an idle cycle
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no prediction pending: event_res %0d", m_event_res);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_res", want.event_res, m_event_res);
                    check_field("target_code", want.target_code, m_target_code);
                    check_field("moving_distance", want.moving_distance, m_moving_distance);
                    check_field("move_energy", want.move_energy, m_move_energy);
                    check_field("stationary_distance", want.stationary_distance,
                                m_stationary_distance);
                    check_field("still_energy", want.still_energy,
                                m_still_energy);
                    check_field("detection_distance", want.detection_distance,
                                m_detection_distance);
                    check_field("record_valid", want.record_valid, m_record_valid);
                end
            end
            // Stall at random for the phase; hold off fully during the long stretch
            m_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct(idle_phase));
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off: the sender keeps offering, so the output
    // register fills and s_ready must drop until the hold ends.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!hold_done && !hold_active && sent_count >= HOLD_AT_ITEM) begin
                hold_active <= 1'b1;
                hold_left   <= HOLD_CYCLES;
            end else if (hold_active) begin
                if (hold_left == 0) begin
                    hold_active <= 1'b0;
                    hold_done   <= 1'b1;
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset once, drain, report.
    // ------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // Wait on the falling edge so the queues are settled
        while (pending_bytes.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(2_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
